// ===== design/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// Hillshade package
// Shared widths, register codes, the queue entry type and gradient saturation.
// ----------------------------------------------------------------------------
package hs_pkg;

  localparam int ELEV_W    = 20;          // elevation sample width
  localparam int SUM_W     = ELEV_W + 3;  // Horn sum width
  localparam int MAX_LINE  = 4096;
  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int LW_W      = 13;          // line width register width
  localparam int CFG_W     = 16;
  localparam int GP_W      = SUM_W + 17;  // raw gradient product width
  localparam int G_W       = 30;          // saturated gradient width
  localparam int SQ_W      = 60;          // radicand width
  localparam int ROOT_W    = 30;
  localparam int AZ_W      = G_W + 16;    // azimuth product width
  localparam int T_W       = AZ_W + 1;
  localparam int ACC_W     = 64;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ZMUL_STEPS = 17;
  localparam int DIV_STEPS  = 8;

  // Configuration register indexes.
  localparam logic [2:0] REG_LINE_WIDTH = 3'd0;
  localparam logic [2:0] REG_COS_ZEN    = 3'd1;
  localparam logic [2:0] REG_SIN_ZEN    = 3'd2;
  localparam logic [2:0] REG_COS_AZ     = 3'd3;
  localparam logic [2:0] REG_SIN_AZ     = 3'd4;
  localparam logic [2:0] REG_X_SCALE    = 3'd5;
  localparam logic [2:0] REG_Y_SCALE    = 3'd6;

  // Lighting and scale settings used by the shading unit.
  typedef struct packed {
    logic [15:0]        cos_zen;
    logic [15:0]        sin_zen;
    logic signed [15:0] cos_az;
    logic signed [15:0] sin_az;
    logic [15:0]        x_scale;
    logic [15:0]        y_scale;
  } light_cfg_t;

  // One window's Horn sums on their way to the shading unit.
  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic                    last;
  } grad_item_t;

  // Clamp a raw gradient to plus or minus 2^28.
  function automatic logic signed [G_W-1:0] sat_grad(input logic signed [GP_W-1:0] g);
    logic signed [GP_W-1:0] lim;
    lim = GP_W'(1) <<< 28;
    if (g > lim) begin
      sat_grad = G_W'(lim);
    end else if (g < -lim) begin
      sat_grad = G_W'(-lim);
    end else begin
      sat_grad = G_W'(g);
    end
  endfunction

endpackage

// ===== design/hs_front.sv =====
// ----------------------------------------------------------------------------
// Hillshade front end
// Takes elevation samples, keeps the two line stores and the 3x3 window, and
// hands Horn sums of every full window to the queue.
// ----------------------------------------------------------------------------
module hs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [hs_pkg::LW_W-1:0]         line_width,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [hs_pkg::ELEV_W-1:0] in_elev,
  input  logic                            in_frame_start,
  output logic                            push,
  output hs_pkg::grad_item_t              push_item,
  input  logic                            q_full
);

  logic signed [hs_pkg::ELEV_W-1:0] older_mem [hs_pkg::MAX_LINE];
  logic signed [hs_pkg::ELEV_W-1:0] newer_mem [hs_pkg::MAX_LINE];

  logic                             busy_r;
  logic [hs_pkg::COL_W-1:0]         col_r;
  logic [1:0]                       row_r;
  logic [hs_pkg::COL_W-1:0]         addr_r;
  logic                             emit_r;
  logic                             last_r;
  logic signed [hs_pkg::ELEV_W-1:0] bot_r;
  logic signed [hs_pkg::ELEV_W-1:0] top_r;
  logic signed [hs_pkg::ELEV_W-1:0] mid_r;
  logic signed [hs_pkg::ELEV_W-1:0] win_r [6];

  logic [hs_pkg::LW_W-1:0]  w_clamp;
  logic [hs_pkg::COL_W-1:0] w_last;
  logic [hs_pkg::COL_W-1:0] col_eff;
  logic [1:0]               row_eff;
  logic                     is_last;
  logic                     accept;
  logic                     fire;
  logic signed [hs_pkg::SUM_W-1:0] sx;
  logic signed [hs_pkg::SUM_W-1:0] sy;

  // Clamp the row width and locate the last column.
  always_comb begin
    if (line_width < hs_pkg::LW_W'(3)) begin
      w_clamp = hs_pkg::LW_W'(3);
    end else if (line_width > hs_pkg::LW_W'(hs_pkg::MAX_LINE)) begin
      w_clamp = hs_pkg::LW_W'(hs_pkg::MAX_LINE);
    end else begin
      w_clamp = line_width;
    end
    w_last  = hs_pkg::COL_W'(w_clamp - hs_pkg::LW_W'(1));
    col_eff = in_frame_start ? '0 : col_r;
    row_eff = in_frame_start ? 2'd0 : row_r;
    is_last = (col_eff >= w_last);
  end

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign fire     = busy_r && (!emit_r || !q_full);
  assign push     = busy_r && emit_r && !q_full;

  // Horn sums: a=w0 b=w3 c=top d=w1 f=mid g=w2 h=w5 i=bot.
  always_comb begin
    sx = (hs_pkg::SUM_W'(top_r) + (hs_pkg::SUM_W'(mid_r) <<< 1) + hs_pkg::SUM_W'(bot_r))
       - (hs_pkg::SUM_W'(win_r[0]) + (hs_pkg::SUM_W'(win_r[1]) <<< 1)
          + hs_pkg::SUM_W'(win_r[2]));
    sy = (hs_pkg::SUM_W'(win_r[2]) + (hs_pkg::SUM_W'(win_r[5]) <<< 1)
          + hs_pkg::SUM_W'(bot_r))
       - (hs_pkg::SUM_W'(win_r[0]) + (hs_pkg::SUM_W'(win_r[3]) <<< 1)
          + hs_pkg::SUM_W'(top_r));
    push_item.sx   = sx;
    push_item.sy   = sy;
    push_item.last = last_r;
  end

  // Position counters and per-sample control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
      row_r  <= 2'd0;
      emit_r <= 1'b0;
      last_r <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        emit_r <= (row_eff == 2'd2) && (col_eff >= hs_pkg::COL_W'(2));
        last_r <= is_last;
        col_r  <= is_last ? '0 : col_eff + hs_pkg::COL_W'(1);
        row_r  <= (is_last && row_eff != 2'd2) ? row_eff + 2'd1 : row_eff;
      end else if (fire) begin
        busy_r   <= 1'b0;
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_r;
        win_r[4] <= mid_r;
        win_r[5] <= bot_r;
      end
    end
  end

  // Sample data and line store reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= col_eff;
      bot_r  <= in_elev;
      top_r  <= older_mem[col_eff];
      mid_r  <= newer_mem[col_eff];
    end
  end

  // Line store writes once the window has moved on.
  always_ff @(posedge clk) begin
    if (fire) begin
      older_mem[addr_r] <= mid_r;
      newer_mem[addr_r] <= bot_r;
    end
  end

endmodule

// ===== design/hs_queue.sv =====
// ----------------------------------------------------------------------------
// Hillshade queue
// Two-entry queue of Horn sums between the front end and the shading unit.
// ----------------------------------------------------------------------------
module hs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hs_pkg::grad_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output hs_pkg::grad_item_t pop_item
);

  hs_pkg::grad_item_t slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = slot_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== design/hs_back.sv =====
// ----------------------------------------------------------------------------
// Hillshade shading unit
// Turns Horn sums into a shade byte: gradient scaling, an iterative square
// root run beside a serial zenith multiply, then a short restoring divide unless the shade clamps.
// ----------------------------------------------------------------------------
module hs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hs_pkg::light_cfg_t lcfg,
  input  logic               q_not_empty,
  input  hs_pkg::grad_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_shade,
  output logic               out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQR, S_SUM, S_ROOT, S_NORM, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  logic signed [hs_pkg::SUM_W-1:0]  sx_r;
  logic signed [hs_pkg::SUM_W-1:0]  sy_r;
  logic                             last_r;
  logic signed [hs_pkg::GP_W-1:0]   gxp_r;
  logic signed [hs_pkg::GP_W-1:0]   gyp_r;
  logic [hs_pkg::SQ_W-1:0]          gx2_r;
  logic [hs_pkg::SQ_W-1:0]          gy2_r;
  logic signed [hs_pkg::AZ_W-1:0]   pa_r;
  logic signed [hs_pkg::AZ_W-1:0]   pc_r;
  logic [hs_pkg::SQ_W-1:0]          rad_r;
  logic [hs_pkg::SQ_W-1:0]          res_r;
  logic [hs_pkg::SQ_W-1:0]          bit_r;
  logic signed [hs_pkg::T_W-1:0]    t_r;
  logic signed [hs_pkg::ACC_W-1:0]  acc_r;
  logic [16:0]                      zs_r;
  logic [4:0]                       cnt_r;
  logic [hs_pkg::ACC_W-1:0]         rem_r;
  logic [hs_pkg::ACC_W-1:0]         dv_r;
  logic [7:0]                       q_r;
  logic [7:0]                       shade_r;
  logic                             ov_r;
  logic [7:0]                       os_r;
  logic                             ol_r;

  logic signed [hs_pkg::G_W-1:0]    gx;
  logic signed [hs_pkg::G_W-1:0]    gy;
  logic [hs_pkg::SQ_W-1:0]          trial;
  logic signed [hs_pkg::ACC_W-1:0]  n_val;
  logic [hs_pkg::ACC_W-1:0]         num;
  logic [hs_pkg::ACC_W-1:0]         den_sh;
  logic                             load;

  assign pop       = (state_r == S_IDLE) && q_not_empty;
  assign load      = (state_r == S_OUT) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_shade = os_r;
  assign out_last  = ol_r;

  // Saturated gradients, square root trial and normalization values.
  always_comb begin
    gx     = hs_pkg::sat_grad(gxp_r);
    gy     = hs_pkg::sat_grad(gyp_r);
    trial  = res_r + bit_r;
    n_val  = ($signed(hs_pkg::ACC_W'(lcfg.cos_zen)) <<< 12) + (acc_r >>> 15);
    num    = (hs_pkg::ACC_W'(n_val) << 8) - hs_pkg::ACC_W'(n_val);
    den_sh = hs_pkg::ACC_W'(res_r[hs_pkg::ROOT_W-1:0]) << 15;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        os_r <= shade_r;
        ol_r <= last_r;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            sx_r    <= q_item.sx;
            sy_r    <= q_item.sy;
            last_r  <= q_item.last;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          gxp_r   <= hs_pkg::GP_W'(sx_r) * $signed({1'b0, lcfg.x_scale});
          gyp_r   <= hs_pkg::GP_W'(sy_r) * $signed({1'b0, lcfg.y_scale});
          state_r <= S_SQR;
        end
        S_SQR: begin
          gx2_r   <= hs_pkg::SQ_W'(unsigned'(hs_pkg::SQ_W'(gx) * hs_pkg::SQ_W'(gx)));
          gy2_r   <= hs_pkg::SQ_W'(unsigned'(hs_pkg::SQ_W'(gy) * hs_pkg::SQ_W'(gy)));
          pa_r    <= hs_pkg::AZ_W'(lcfg.sin_az) * hs_pkg::AZ_W'(gy);
          pc_r    <= hs_pkg::AZ_W'(lcfg.cos_az) * hs_pkg::AZ_W'(gx);
          state_r <= S_SUM;
        end
        S_SUM: begin
          rad_r   <= (hs_pkg::SQ_W'(1) << 24) + gx2_r + gy2_r;
          t_r     <= hs_pkg::T_W'(pa_r) - hs_pkg::T_W'(pc_r);
          res_r   <= '0;
          bit_r   <= hs_pkg::SQ_W'(1) << (hs_pkg::SQ_W - 2);
          acc_r   <= '0;
          zs_r    <= {lcfg.sin_zen[15:0], 1'b0} >> 1;
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // Two radicand bits per cycle.
          if (rad_r >= trial) begin
            rad_r <= rad_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          // Zenith sine times t, one multiplier bit per cycle, MSB first.
          if (cnt_r < 5'(hs_pkg::ZMUL_STEPS)) begin
            acc_r <= (acc_r <<< 1) + (zs_r[16] ? hs_pkg::ACC_W'(t_r) : '0);
            zs_r  <= zs_r << 1;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(hs_pkg::ROOT_STEPS - 1)) begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          cnt_r <= '0;
          q_r   <= '0;
          if (n_val <= 0) begin
            shade_r <= 8'd0;
            state_r <= S_OUT;
          end else if (num >= (den_sh << 8)) begin
            shade_r <= 8'd255;
            state_r <= S_OUT;
          end else begin
            rem_r   <= num;
            dv_r    <= den_sh << (hs_pkg::DIV_STEPS - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= dv_r) begin
            rem_r <= rem_r - dv_r;
            q_r   <= {q_r[6:0], 1'b1};
          end else begin
            q_r   <= {q_r[6:0], 1'b0};
          end
          dv_r  <= dv_r >> 1;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(hs_pkg::DIV_STEPS - 1)) begin
            shade_r <= (rem_r >= dv_r) ? {q_r[6:0], 1'b1} : {q_r[6:0], 1'b0};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The queue is only drained while the unit is free.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_MUL))
    else $error("pop outside idle");

  // The output register is only loaded when its slot is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !load)
    else $error("output overwritten");

  // The root loop never runs past its step count.
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (cnt_r < 5'(hs_pkg::ROOT_STEPS)))
    else $error("root loop overrun");

  // A loaded result shows valid in the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ov_r)
    else $error("loaded result not valid");

endmodule

// ===== design/hillshade_3x3_core.sv =====
// ----------------------------------------------------------------------------
// Hillshade 3x3 core
// Horn hillshade over a row-ordered elevation stream, one shade byte for each
// full 3x3 window.
//
//   channel | dir | contents
//   in_     | in  | tdata[19:0] elevation, tuser frame_start
//   out_    | out | tdata[7:0] shade, tlast row_end
//   cfg_    | in  | we, index[2:0], wdata[15:0]
//
// The front end reads a sample's column from the line stores, then writes it
// back, and takes no new sample in between. A shade result passes the 30-step
// square root loop and, unless it clamps, the 8-step divide; samples that give
// no result are not held back by the two-entry queue, even when it is full.
// Reset is synchronous, clears counters and valid flags and loads the
// configuration defaults.
// ----------------------------------------------------------------------------
module hillshade_3x3_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] elevation, [23:20] zero
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] shade
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [hs_pkg::LW_W-1:0] line_width_r;
  hs_pkg::light_cfg_t      lcfg_r;
  logic                    push;
  hs_pkg::grad_item_t      push_item;
  logic                    q_full;
  logic                    pop;
  logic                    q_not_empty;
  hs_pkg::grad_item_t      pop_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= hs_pkg::LW_W'(4096);
      lcfg_r.cos_zen <= 16'd23170;
      lcfg_r.sin_zen <= 16'd23170;
      lcfg_r.cos_az  <= -16'sd23170;
      lcfg_r.sin_az  <= -16'sd23170;
      lcfg_r.x_scale <= 16'd32;
      lcfg_r.y_scale <= 16'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        hs_pkg::REG_LINE_WIDTH: line_width_r   <= cfg_wdata[hs_pkg::LW_W-1:0];
        hs_pkg::REG_COS_ZEN:    lcfg_r.cos_zen <= cfg_wdata;
        hs_pkg::REG_SIN_ZEN:    lcfg_r.sin_zen <= cfg_wdata;
        hs_pkg::REG_COS_AZ:     lcfg_r.cos_az  <= cfg_wdata;
        hs_pkg::REG_SIN_AZ:     lcfg_r.sin_az  <= cfg_wdata;
        hs_pkg::REG_X_SCALE:    lcfg_r.x_scale <= cfg_wdata;
        hs_pkg::REG_Y_SCALE:    lcfg_r.y_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_width     (line_width_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_elev        (in_tdata[hs_pkg::ELEV_W-1:0]),
    .in_frame_start (in_tuser),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  hs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  hs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lcfg        (lcfg_r),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_shade   (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

// ===== tb/sv/hillshade_3x3_checker.sv =====
// ----------------------------------------------------------------------------
// Hillshade 3x3 checker
// Watches the input, result and register ports of the hillshade core. It keeps
// its own copy of the line stores, window and settings, predicts the shade
// result of every accepted sample that completes a full window and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module hillshade_3x3_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] elevation, [23:20] zero
  input  logic        in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] shade
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] shade;
    logic       row_end;
  } shade_px_t;

  // Model copy of the window state.
  logic signed [hs_pkg::ELEV_W-1:0] older_row[hs_pkg::MAX_LINE];
  logic signed [hs_pkg::ELEV_W-1:0] newer_row[hs_pkg::MAX_LINE];
  logic signed [hs_pkg::ELEV_W-1:0] win[6];
  int unsigned                      col_cnt;
  int unsigned                      row_cnt;

  // Model copy of the settings.
  logic [hs_pkg::LW_W-1:0] line_w;
  logic [15:0]             cos_zen, sin_zen, x_scale, y_scale;
  logic signed [15:0]      cos_az, sin_az;

  shade_px_t expected_px[$];
  int        reported;

  // Bitwise integer square root, rounded down.
  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_grad(input longint g);
    longint lim;
    lim = 64'sd1 <<< 28;
    if (g > lim) return lim;
    if (g < -lim) return -lim;
    return g;
  endfunction

  // Horn gradients and lit value of one window, a..i in row order.
  function automatic logic [7:0] horn_shade(input longint a, input longint b,
                                            input longint c, input longint d,
                                            input longint f, input longint g,
                                            input longint h, input longint i);
    longint sx, sy, gx, gy, t, term, n;
    longint unsigned den, v;
    sx   = (c + 2 * f + i) - (a + 2 * d + g);
    sy   = (g + 2 * h + i) - (a + 2 * b + c);
    gx   = clamp_grad(sx * longint'(x_scale));
    gy   = clamp_grad(sy * longint'(y_scale));
    den  = int_root((64'd1 << 24) + longint'(gx * gx) + longint'(gy * gy));
    t    = longint'(sin_az) * gy - longint'(cos_az) * gx;
    term = (longint'(sin_zen) * t) >>> 15;
    n    = (longint'(cos_zen) <<< 12) + term;
    if (n <= 0) return 8'd0;
    v = (longint'(n) * 255) / (den << 15);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Advance the model by one accepted sample.
  task automatic take_sample(input logic signed [hs_pkg::ELEV_W-1:0] bot, input logic fs);
    int unsigned w, c;
    logic signed [hs_pkg::ELEV_W-1:0] top, mid;
    logic last;
    shade_px_t px;
    w = line_w;
    if (w < 3) w = 3;
    if (w > hs_pkg::MAX_LINE) w = hs_pkg::MAX_LINE;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = (col_cnt >= hs_pkg::MAX_LINE) ? hs_pkg::MAX_LINE - 1 : col_cnt;
    last = (c >= w - 1);
    top = older_row[c];
    mid = newer_row[c];
    older_row[c] = mid;
    newer_row[c] = bot;
    if (row_cnt >= 2 && c >= 2) begin
      px.shade   = horn_shade(win[0], win[3], top, win[1], mid, win[2], win[5], bot);
      px.row_end = last;
      expected_px.push_back(px);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    if (last) begin
      col_cnt = 0;
      if (row_cnt < 2) row_cnt++;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    reported   = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hs_pkg::MAX_LINE; k++) begin
        older_row[k] = '0;
        newer_row[k] = '0;
      end
      for (int k = 0; k < 6; k++) win[k] = '0;
      col_cnt = 0;
      row_cnt = 0;
      line_w  = 13'd4096;
      cos_zen = 16'd23170;
      sin_zen = 16'd23170;
      cos_az  = -16'sd23170;
      sin_az  = -16'sd23170;
      x_scale = 16'd32;
      y_scale = 16'd32;
      expected_px.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          hs_pkg::REG_LINE_WIDTH: line_w  = cfg_wdata[hs_pkg::LW_W-1:0];
          hs_pkg::REG_COS_ZEN:    cos_zen = cfg_wdata;
          hs_pkg::REG_SIN_ZEN:    sin_zen = cfg_wdata;
          hs_pkg::REG_COS_AZ:     cos_az  = cfg_wdata;
          hs_pkg::REG_SIN_AZ:     sin_az  = cfg_wdata;
          hs_pkg::REG_X_SCALE:    x_scale = cfg_wdata;
          hs_pkg::REG_Y_SCALE:    y_scale = cfg_wdata;
          default: ;
        endcase
      end
      // Sample transfers feed the prediction.
      if (in_tvalid && in_tready) take_sample(in_tdata[hs_pkg::ELEV_W-1:0], in_tuser);
      // Result transfers are compared with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_px.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result shade=%0d row_end=%0b",
                     $realtime, out_tdata, out_tlast);
          end
        end else begin
          shade_px_t px;
          px = expected_px.pop_front();
          if (px.shade !== out_tdata || px.row_end !== out_tlast) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch shade exp=%0d got=%0d, row_end exp=%0b got=%0b",
                       $realtime, px.shade, out_tdata, px.row_end, out_tlast);
            end
          end
        end
      end
    end
    pending = expected_px.size();
  end

endmodule

// ===== tb/sv/tb_hillshade_3x3_core.sv =====
// ----------------------------------------------------------------------------
// Hillshade 3x3 core testbench
// Streams directed and random elevation frames through the core under a range
// of sun angles, gradient scales and line widths, with random gaps on the
// input and random stalls on the output. The checker beside the core predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_hillshade_3x3_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [19:0] elevation, [23:20] zero
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] shade
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;

  int          samples_sent;
  int          burst_left;
  int          cycle_cnt;

  hillshade_3x3_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  hillshade_3x3_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: stalls follow one of four random patterns in turn, and once the
  // receiver holds off for a long stretch so that the core backs up to its input.
  initial begin
    int mode;
    int held;
    held = 0;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 64; k++) begin
        @(negedge clk);
        if (held == 0 && samples_sent >= 250) begin
          held = 1;
          out_tready = 1'b0;
          repeat (700) @(negedge clk);
        end
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = $urandom_range(0, 1);
          2:       out_tready = ($urandom_range(0, 7) == 0);
          default: out_tready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic write_light(input logic [15:0] lw, input logic [15:0] cz,
                             input logic [15:0] sz, input logic [15:0] ca,
                             input logic [15:0] sa, input logic [15:0] xs,
                             input logic [15:0] ys);
    write_reg(hs_pkg::REG_LINE_WIDTH, lw);
    write_reg(hs_pkg::REG_COS_ZEN, cz);
    write_reg(hs_pkg::REG_SIN_ZEN, sz);
    write_reg(hs_pkg::REG_COS_AZ, ca);
    write_reg(hs_pkg::REG_SIN_AZ, sa);
    write_reg(hs_pkg::REG_X_SCALE, xs);
    write_reg(hs_pkg::REG_Y_SCALE, ys);
  endtask

  // Wait until every predicted result has come, then let samples that give
  // no result clear the front end.
  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // One sample transfer; valid stays high inside a burst.
  task automatic send_sample(input logic [hs_pkg::ELEV_W-1:0] elev, input logic fs);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, elev};
    in_tuser  = fs;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // A frame of rough or smooth terrain; cut short gives a broken frame.
  task automatic send_frame(input int width, input int rows, input int cut);
    logic [hs_pkg::ELEV_W-1:0] base;
    int amp;
    int total;
    base  = $urandom();
    amp   = 1 << $urandom_range(0, 19);
    total = width * rows - cut;
    for (int k = 0; k < total; k++) begin
      base = base + hs_pkg::ELEV_W'($urandom_range(0, 2 * amp) - amp);
      send_sample($urandom_range(0, 15) == 0 ? hs_pkg::ELEV_W'($urandom()) : base,
                  k == 0 || $urandom_range(0, 400) == 0);
    end
  endtask

  function automatic logic [15:0] pick_q15(input logic is_signed);
    case ($urandom_range(0, 5))
      0:       return is_signed ? 16'h8000 : 16'd0;
      1:       return is_signed ? 16'h7fff : 16'd32768;
      default: return is_signed ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_scale;
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, 512));
    endcase
  endfunction

  initial begin
    int width;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = hs_pkg::REG_LINE_WIDTH;
    cfg_wdata    = '0;
    samples_sent = 0;
    burst_left   = 0;
    rst_n        = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Narrowest line, extreme elevations that saturate the gradients.
    write_light(16'd3, 16'd23170, 16'd23170, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    for (int k = 0; k < 12; k++)
      send_sample((k % 3 == 2) ? 20'h7ffff : 20'h80000, k == 0);
    drain();

    // Zenith cosine and sine both at one over a sloped patch, with a line width
    // below three that acts as three.
    write_light(16'd1, 16'd32768, 16'd32768, 16'h7fff, 16'd0, 16'd256, 16'd256);
    for (int k = 0; k < 9; k++) send_sample(20'(k * 16 * (k % 3)), k == 0);
    drain();

    // Width shrunk in the middle of a row: row 2 column 3 of a width-6 frame,
    // then a width below three acts as three and ends the row at once.
    write_light(16'd6, 16'd0, 16'd32768, 16'h7fff, 16'h7fff, 16'd32, 16'd32);
    for (int k = 0; k < 16; k++) send_sample(20'($urandom()), k == 0);
    drain();
    write_reg(hs_pkg::REG_LINE_WIDTH, 16'd0);
    for (int k = 0; k < 7; k++) send_sample(20'($urandom()), 1'b0);
    drain();

    // Width above the largest line acts as the largest line, so a short
    // frame never ends its first row.
    write_reg(hs_pkg::REG_LINE_WIDTH, 16'h1fff);
    for (int k = 0; k < 20; k++)
      send_sample(20'($urandom_range(0, 4095)), k == 0);
    drain();

    // Random phases of settings and frames.
    while (samples_sent < 550) begin
      case ($urandom_range(0, 9))
        0:       width = $urandom_range(0, 2);
        1:       width = $urandom_range(20, 40);
        default: width = $urandom_range(3, 10);
      endcase
      write_light(16'(width), pick_q15(1'b0), pick_q15(1'b0), pick_q15(1'b1),
                  pick_q15(1'b1), pick_scale(), pick_scale());
      if (width < 3) width = 3;
      repeat ($urandom_range(1, 3))
        send_frame(width, $urandom_range(3, 6),
                   $urandom_range(0, 9) == 0 ? $urandom_range(1, width) : 0);
      drain();
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
